// ===== rtl/tsb_pkg.sv =====
// Package for the periodic timer slot bank.
// Holds sizes, the command codes, the transfer types and the cell control and status types.
// No dependencies.
package tsb_pkg;

  localparam int unsigned SLOTS      = 8;
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned MASK_W     = (SLOTS > 8) ? SLOTS : 8;

  typedef enum logic [1:0] {
    CMD_TICK        = 2'd0,
    CMD_ALLOC       = 2'd1,
    CMD_RELEASE     = 2'd2,
    CMD_RELEASE_ALL = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] period;
    logic [2:0]  slot;
  } in_t;

  typedef struct packed {
    logic [7:0] fire_mask;
    logic       alloc_ok;
    logic [2:0] alloc_slot;
    logic [7:0] active_mask;
  } out_t;

  typedef struct packed {
    logic                  tick;
    logic                  alloc;
    logic                  release_all;
    logic [COUNT_BITS-1:0] period;
  } cell_ctl_t;

  typedef struct packed {
    logic active_next;
    logic fire;
    logic claim;
  } cell_stat_t;

endpackage

// ===== rtl/tsb_cell.sv =====
// One timer slot: active bit, reload period and remaining count.
// Passes the free-slot search on to the next cell. Depends on tsb_pkg.
module tsb_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  tsb_pkg::cell_ctl_t ctl_i,
  input  logic               release_i,
  input  logic               taken_i,
  output logic               taken_o,
  output tsb_pkg::cell_stat_t stat_o
);
  import tsb_pkg::*;

  logic                  active_q, active_d;
  logic [COUNT_BITS-1:0] reload_q, reload_d;
  logic [COUNT_BITS-1:0] remain_q, remain_d;
  logic                  claim, fire;

  assign claim   = ctl_i.alloc && !taken_i && !active_q;
  assign taken_o = taken_i || !active_q;
  assign fire    = ctl_i.tick && active_q && (remain_q == COUNT_BITS'(1));

  always_comb begin
    active_d = active_q;
    reload_d = reload_q;
    remain_d = remain_q;
    if (claim) begin
      active_d = 1'b1;
      reload_d = ctl_i.period;
      remain_d = ctl_i.period;
    end else if (fire) begin
      remain_d = reload_q;
    end else if (ctl_i.tick && active_q) begin
      remain_d = remain_q - COUNT_BITS'(1);
    end
    if (ctl_i.release_all || release_i) begin
      active_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (en_i) begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      reload_q <= reload_d;
      remain_q <= remain_d;
    end
  end

  assign stat_o = '{active_next: active_d, fire: fire, claim: claim};

endmodule

// ===== rtl/periodic_timer_slot_bank.sv =====
// Periodic timer slot bank: a chain of timer cells with tick, allocate and release.
// The result transfer comes in the cycle after the command transfer.
// Throughput: one command per cycle; busy_o stays low and the receiver cannot stall.
// Reset clears every active bit and the done strobe; slot counters hold no value
// until their slot is allocated. Depends on tsb_pkg and tsb_cell.
module periodic_timer_slot_bank (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  tsb_pkg::in_t item_i,
  output logic         busy_o,
  output logic         done_o,
  output tsb_pkg::out_t result_o
);
  import tsb_pkg::*;

  logic                accept;
  cell_ctl_t           ctl;
  logic [SLOTS-1:0]    rel_hit;
  logic [SLOTS:0]      taken;
  cell_stat_t          stat [SLOTS];
  logic [MASK_W-1:0]   fire_vec, active_vec;
  logic [SLOTS-1:0]    claim_vec;
  logic [2:0]          where;
  out_t                res_d, res_q;
  logic                done_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign ctl.tick        = (cmd_e'(item_i.command) == CMD_TICK);
  assign ctl.alloc       = (cmd_e'(item_i.command) == CMD_ALLOC);
  assign ctl.release_all = (cmd_e'(item_i.command) == CMD_RELEASE_ALL);
  assign ctl.period      = COUNT_BITS'(item_i.period);

  assign taken[0] = 1'b0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    assign rel_hit[i] = (cmd_e'(item_i.command) == CMD_RELEASE) &&
                        (32'(item_i.slot) == 32'(i));
    tsb_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (accept),
      .ctl_i    (ctl),
      .release_i(rel_hit[i]),
      .taken_i  (taken[i]),
      .taken_o  (taken[i+1]),
      .stat_o   (stat[i])
    );
  end

  always_comb begin
    fire_vec   = '0;
    active_vec = '0;
    claim_vec  = '0;
    where      = '0;
    for (int i = 0; i < SLOTS; i++) begin
      fire_vec[i]   = stat[i].fire;
      active_vec[i] = stat[i].active_next;
      claim_vec[i]  = stat[i].claim;
      if (stat[i].claim) begin
        where = where | 3'(i);
      end
    end
  end

  always_comb begin
    res_d.fire_mask   = fire_vec[7:0];
    res_d.alloc_ok    = |claim_vec;
    res_d.alloc_slot  = where;
    res_d.active_mask = active_vec[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef SYNTHESIS
  a_claim_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.alloc_ok) |-> result_o.active_mask[result_o.alloc_slot])
    else $error("claimed slot is not active");

  a_fire_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((result_o.fire_mask & ~result_o.active_mask) == 8'd0))
    else $error("fired slot is not active");

  a_fire_or_alloc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.fire_mask == 8'd0 || !result_o.alloc_ok))
    else $error("fire and allocate in one result");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for periodic_timer_slot_bank: random and directed command
// transfers, each result compared field by field against a cycle-free timer model.
// Depends on tsb_pkg and the periodic_timer_slot_bank RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tsb_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS = 640;

  typedef struct {
    in_t         item;
    int unsigned gap;
    bit          drain;
  } stim_t;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  in_t  item_i;
  logic busy_o;
  logic done_o;
  out_t result_o;

  stim_t       pending_q[$];
  out_t        expected_q[$];
  logic        slot_on[SLOTS];
  logic [31:0] reload_cnt[SLOTS];
  logic [31:0] remain_cnt[SLOTS];
  logic        took;
  int unsigned mismatches;
  int unsigned idle_cycles;

  periodic_timer_slot_bank u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .item_i  (item_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .result_o(result_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic out_t timer_predict(in_t it);
    out_t r;
    bit   found;
    r = '0;
    found = 1'b0;
    case (cmd_e'(it.command))
      CMD_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_on[i]) begin
            remain_cnt[i] = remain_cnt[i] - 32'd1;
            if (remain_cnt[i] == 32'd0) begin
              r.fire_mask[i] = 1'b1;
              remain_cnt[i] = reload_cnt[i];
            end
          end
        end
      end
      CMD_ALLOC: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && !slot_on[i]) begin
            found = 1'b1;
            slot_on[i] = 1'b1;
            reload_cnt[i] = it.period;
            remain_cnt[i] = it.period;
            r.alloc_ok = 1'b1;
            r.alloc_slot = 3'(i);
          end
        end
      end
      CMD_RELEASE: begin
        if (it.slot < SLOTS) slot_on[it.slot] = 1'b0;
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) slot_on[i] = 1'b0;
      end
    endcase
    for (int i = 0; i < 8; i++) r.active_mask[i] = slot_on[i];
    return r;
  endfunction

  task automatic add_item(cmd_e cmd, logic [31:0] period, logic [2:0] slot, bit quiet,
                          bit drain);
    stim_t s;
    s.item.command = cmd;
    s.item.period = period;
    s.item.slot = slot;
    s.gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
    s.drain = drain;
    pending_q.push_back(s);
  endtask

  // Results are checked before the prediction for a transfer in the same cycle is queued.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: fire=%h ok=%b slot=%0d active=%h",
                     result_o.fire_mask, result_o.alloc_ok, result_o.alloc_slot,
                     result_o.active_mask);
        end else begin
          want = expected_q.pop_front();
          if (result_o.fire_mask !== want.fire_mask || result_o.alloc_ok !== want.alloc_ok ||
              result_o.alloc_slot !== want.alloc_slot ||
              result_o.active_mask !== want.active_mask) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected fire=%h ok=%b slot=%0d active=%h",
                       want.fire_mask, want.alloc_ok, want.alloc_slot, want.active_mask);
              $display("          got      fire=%h ok=%b slot=%0d active=%h",
                       result_o.fire_mask, result_o.alloc_ok, result_o.alloc_slot,
                       result_o.active_mask);
            end
          end
        end
      end
      if (start_i && !busy_o) begin
        expected_q.push_back(timer_predict(item_i));
        took <= 1'b1;
      end else begin
        took <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!start_i || took) begin
      if (pending_q.size() == 0) begin
        start_i <= 1'b0;
      end else if (pending_q[0].gap != 0) begin
        pending_q[0].gap = pending_q[0].gap - 1;
        start_i <= 1'b0;
      end else if (pending_q[0].drain && expected_q.size() != 0) begin
        start_i <= 1'b0;
      end else begin
        item_i <= pending_q[0].item;
        start_i <= 1'b1;
        void'(pending_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("periodic_timer_slot_bank regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int unsigned pick;
    cmd_e        cmd;
    logic [31:0] period;
    bit          quiet;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    item_i = '0;
    took = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    for (int i = 0; i < SLOTS; i++) slot_on[i] = 1'b0;

    add_item(CMD_TICK, 32'hFFFF_FFFF, 3'd7, 0, 0);
    add_item(CMD_ALLOC, 32'd1, 3'd5, 0, 0);
    add_item(CMD_ALLOC, 32'd0, 3'd0, 0, 0);
    add_item(CMD_ALLOC, 32'hFFFF_FFFF, 3'd7, 0, 0);
    for (int p = 2; p <= 6; p++) add_item(CMD_ALLOC, 32'(p), 3'(p), 0, 0);
    add_item(CMD_ALLOC, 32'd3, 3'd2, 0, 0);
    for (int i = 0; i < 6; i++) add_item(CMD_TICK, $urandom(), 3'($urandom_range(0, 7)), 0, 0);
    add_item(CMD_RELEASE, 32'hFFFF_FFFF, 3'd7, 0, 0);
    add_item(CMD_RELEASE, 32'd0, 3'd7, 0, 0);
    add_item(CMD_RELEASE, 32'd9, 3'd0, 0, 0);
    add_item(CMD_ALLOC, 32'd3, 3'd0, 0, 0);
    for (int i = 0; i < 3; i++) add_item(CMD_TICK, 32'd0, 3'd0, 0, 0);
    add_item(CMD_RELEASE_ALL, 32'hFFFF_FFFF, 3'd7, 0, 0);
    add_item(CMD_TICK, 32'd0, 3'd0, 0, 0);
    add_item(CMD_RELEASE, 32'd0, 3'd5, 0, 1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) cmd = CMD_TICK;
      else if (pick < 72) cmd = CMD_ALLOC;
      else if (pick < 96) cmd = CMD_RELEASE;
      else cmd = CMD_RELEASE_ALL;
      pick = $urandom_range(0, 9);
      if (pick < 7) period = $urandom_range(1, 12);
      else if (pick == 7) period = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
      else period = $urandom();
      quiet = (n >= RANDOM_ITEMS - 120);
      add_item(cmd, period, 3'($urandom_range(0, 7)), quiet, (n % 150) == 75);
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    while (pending_q.size() != 0 || start_i || expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("periodic_timer_slot_bank regression: pass");
    end else begin
      $display("periodic_timer_slot_bank regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tsb_pkg.sv
rtl/tsb_cell.sv
rtl/periodic_timer_slot_bank.sv
tb/tb_top.sv
